FILE: rtl/core/bht_pkg.sv
package bht_pkg;

  // Result codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Fixed field widths of the channels
  localparam int KEY_FIELD_BITS     = 16;
  localparam int PAYLOAD_FIELD_BITS = 32;
  localparam int BUCKET_FIELD_BITS  = 5;
  localparam int SLOT_FIELD_BITS    = 3;

  typedef struct packed {
    logic                          opcode;
    logic [KEY_FIELD_BITS-1:0]     key;
    logic [PAYLOAD_FIELD_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    status_t                       status;
    logic [BUCKET_FIELD_BITS-1:0]  bucket;
    logic [SLOT_FIELD_BITS-1:0]    slot;
    logic [PAYLOAD_FIELD_BITS-1:0] found_payload;
  } rsp_t;

  // Decision from the slot compare stage
  typedef struct packed {
    status_t status;
    logic    wr_en;
  } match_ctl_t;

endpackage

FILE: rtl/core/bucket_hash_table_insert_search.sv
// Channel | Handshake           | Payload | Carries
// request | req_valid/req_ready | req_t   | opcode, key, payload
// result  | rsp_valid/rsp_ready | rsp_t   | status, bucket, slot, found_payload
//
// One request per cycle while the result is not blocked; each result passes the input
// register, the bucket multiply and the row read into the compare, and its result is
// held in the output register until taken.
// The bucket row is read into stage c and written by the compare stage when the pipe
// advances; a one-entry bypass covers a write to the row just read.
// Reset clears the slot valid bits at once; the block takes requests right away.
// A stalled result freezes the whole pipe and drops req_ready.
module bucket_hash_table_insert_search
  import bht_pkg::*;
#(
  parameter int NUM_BUCKETS  = 32,
  parameter int SLOTS        = 5,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int KW  = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
  localparam int PW  = (PAYLOAD_BITS < PAYLOAD_FIELD_BITS) ? PAYLOAD_BITS
                                                            : PAYLOAD_FIELD_BITS;
  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int NBW = $clog2(NUM_BUCKETS + 1);
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // ceil(2^32 / NUM_BUCKETS): exact quotient for any 16-bit key
  localparam logic [31:0] RECIP =
    32'(((64'd1 << 32) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  logic adv;

  // Stage a: input register
  logic          va;
  logic          a_op;
  logic [KW-1:0] a_key;
  logic [PW-1:0] a_pay;

  // Stage b: fractional part of key / NUM_BUCKETS
  logic          vb;
  logic          b_op;
  logic [KW-1:0] b_key;
  logic [PW-1:0] b_pay;
  logic [31:0]   b_frac;
  logic [KW+31:0] prod_a;
  logic [NBW+31:0] prod_b;
  logic [BW-1:0] bucket_b;

  // Stage c: row read data and compare
  logic          vc;
  logic          c_op;
  logic [KW-1:0] c_key;
  logic [PW-1:0] c_pay;
  logic [BW-1:0] c_bucket;

  logic [SLOTS-1:0] slot_valid [NUM_BUCKETS];
  logic [KW-1:0]    rd_key  [SLOTS];
  logic [PW-1:0]    rd_pay  [SLOTS];
  logic [KW-1:0]    row_key [SLOTS];
  logic [PW-1:0]    row_pay [SLOTS];

  match_ctl_t    ctl;
  logic [SW-1:0] match_slot;
  logic [PW-1:0] match_pay;
  logic          wr_fire;

  // Bypass of the write made at the edge the current row was read
  logic          fwd_valid;
  logic [BW-1:0] fwd_bucket;
  logic [SW-1:0] fwd_slot;
  logic [KW-1:0] fwd_key;
  logic [PW-1:0] fwd_pay;

  // Advance the whole pipe unless the result register is blocked
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      rsp_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (adv) begin
      va        <= req_valid;
      vb        <= va;
      vc        <= vb;
      rsp_valid <= vc;
      fwd_valid <= wr_fire;
    end
  end

  // Multiply by the reciprocal; keep the low word as the fraction
  assign prod_a = (KW + 32)'(a_key) * (KW + 32)'(RECIP);
  // Scale the fraction back up; the integer part is the remainder
  assign prod_b = (NBW + 32)'(b_frac) * (NBW + 32)'(NUM_BUCKETS);
  assign bucket_b = prod_b[32 +: BW];

  // Advance payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_op     <= req.opcode;
      a_key    <= req.key[KW-1:0];
      a_pay    <= req.payload[PW-1:0];
      b_op     <= a_op;
      b_key    <= a_key;
      b_pay    <= a_pay;
      b_frac   <= prod_a[31:0];
      c_op     <= b_op;
      c_key    <= b_key;
      c_pay    <= b_pay;
      c_bucket <= bucket_b;
      fwd_bucket <= c_bucket;
      fwd_slot   <= match_slot;
      fwd_key    <= c_key;
      fwd_pay    <= c_pay;
    end
  end

  assign wr_fire = adv && vc && ctl.wr_en;

  // Slot occupancy: clear on reset, set on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        slot_valid[b] <= '0;
      end
    end else if (wr_fire) begin
      slot_valid[c_bucket][match_slot] <= 1'b1;
    end
  end

  // One key and payload store per slot, addressed by bucket
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    logic [KW+PW-1:0] rdata;

    bht_slot_mem #(
      .DEPTH (NUM_BUCKETS),
      .DW    (KW + PW)
    ) u_mem (
      .clk   (clk),
      .we    (wr_fire && match_slot == SW'(s)),
      .waddr (c_bucket),
      .wdata ({c_key, c_pay}),
      .re    (adv),
      .raddr (bucket_b),
      .rdata (rdata)
    );

    assign rd_key[s] = rdata[PW +: KW];
    assign rd_pay[s] = rdata[PW-1:0];

    // Patch in the write the row read missed
    always_comb begin
      if (fwd_valid && fwd_bucket == c_bucket && fwd_slot == SW'(s)) begin
        row_key[s] = fwd_key;
        row_pay[s] = fwd_pay;
      end else begin
        row_key[s] = rd_key[s];
        row_pay[s] = rd_pay[s];
      end
    end
  end

  bht_match #(
    .SLOTS (SLOTS),
    .KW    (KW),
    .PW    (PW),
    .SW    (SW)
  ) u_match (
    .op        (c_op),
    .key       (c_key),
    .row_valid (slot_valid[c_bucket]),
    .row_key   (row_key),
    .row_pay   (row_pay),
    .ctl       (ctl),
    .slot      (match_slot),
    .found     (match_pay)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (adv && vc) begin
      rsp.status        <= ctl.status;
      rsp.bucket        <= BUCKET_FIELD_BITS'(c_bucket);
      rsp.slot          <= SLOT_FIELD_BITS'(match_slot);
      rsp.found_payload <= PAYLOAD_FIELD_BITS'(match_pay);
    end
  end

endmodule

FILE: rtl/core/bht_slot_mem.sv
module bht_slot_mem #(
  parameter int DEPTH = 32,
  parameter int DW    = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry; registered read returns the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bht_match.sv
module bht_match
  import bht_pkg::*;
#(
  parameter int SLOTS = 5,
  parameter int KW    = 16,
  parameter int PW    = 32,
  parameter int SW    = 3
) (
  input  logic             op,
  input  logic [KW-1:0]    key,
  input  logic [SLOTS-1:0] row_valid,
  input  logic [KW-1:0]    row_key [SLOTS],
  input  logic [PW-1:0]    row_pay [SLOTS],
  output match_ctl_t       ctl,
  output logic [SW-1:0]    slot,
  output logic [PW-1:0]    found
);

  // Pick the lowest free slot on insert, the lowest matching slot on search
  always_comb begin
    logic          any;
    logic [SW-1:0] pick;
    logic [PW-1:0] pick_pay;
    any      = 1'b0;
    pick     = '0;
    pick_pay = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (op == OP_INSERT) begin
        if (!row_valid[s]) begin
          any  = 1'b1;
          pick = SW'(s);
        end
      end else begin
        if (row_valid[s] && row_key[s] == key) begin
          any      = 1'b1;
          pick     = SW'(s);
          pick_pay = row_pay[s];
        end
      end
    end

    ctl.wr_en = (op == OP_INSERT) && any;
    if (op == OP_INSERT) begin
      ctl.status = any ? ST_INSERTED : ST_FULL;
    end else begin
      ctl.status = any ? ST_FOUND : ST_MISSING;
    end
    slot  = any ? pick : '0;
    found = pick_pay;
  end

endmodule

FILE: rtl/core/bht_checker.sv
module bht_checker
  import bht_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // No result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A blocked result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // A blocked result stalls the request side
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while result blocked");

  // With no result pending, requests are always taken
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with empty output");

  // Full and miss report no slot and no payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_MISSING)
      |-> rsp.slot == '0 && rsp.found_payload == '0)
    else $error("nonzero slot or payload on full or miss");

endmodule

bind bucket_hash_table_insert_search bht_checker u_bht_checker (.*);
